FILE: hdl/svx_pkg.sv
package svx_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0]        angle;
    logic [31:0]        color;
    logic [15:0]        texture_id;
    logic [15:0]        tiling;
    logic               scene_start;
  } quad_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        vert_color;
    logic               tex_u;
    logic               tex_v;
    logic [4:0]         tex_slot;
    logic [15:0]        vert_tiling;
    logic               flush_before;
    logic [13:0]        batch_quad_index;
    logic               last_vertex;
  } vert_t;

  typedef struct packed {
    logic [4:0]  slot;
    logic [13:0] index;
    logic        flush;
  } slot_res_t;

  typedef struct packed {
    logic       load;
    logic [3:0] mul_sel;
    logic [3:0] wr_sel;
    logic       corner;
    logic       emit;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic slot_done;
    logic out_busy;
  } sts_t;

  localparam logic [3:0] MUL_NONE = 4'd0;
  localparam logic [3:0] MUL_XX   = 4'd1;
  localparam logic [3:0] MUL_X2D  = 4'd2;
  localparam logic [3:0] MUL_X2H  = 4'd3;
  localparam logic [3:0] MUL_X2TS = 4'd4;
  localparam logic [3:0] MUL_X2TC = 4'd5;
  localparam logic [3:0] MUL_XTS  = 4'd6;
  localparam logic [3:0] MUL_SXC  = 4'd7;
  localparam logic [3:0] MUL_SYS  = 4'd8;
  localparam logic [3:0] MUL_SXS  = 4'd9;
  localparam logic [3:0] MUL_SYC  = 4'd10;

  localparam logic [3:0] WR_NONE = 4'd0;
  localparam logic [3:0] WR_X2   = 4'd1;
  localparam logic [3:0] WR_TS_C = 4'd2;
  localparam logic [3:0] WR_TC_G = 4'd3;
  localparam logic [3:0] WR_TS_B = 4'd4;
  localparam logic [3:0] WR_TC_F = 4'd5;
  localparam logic [3:0] WR_TS_A = 4'd6;
  localparam logic [3:0] WR_TC_E = 4'd7;
  localparam logic [3:0] WR_SIN  = 4'd8;
  localparam logic [3:0] WR_COS  = 4'd9;
  localparam logic [3:0] WR_SC   = 4'd10;
  localparam logic [3:0] WR_PXC  = 4'd11;
  localparam logic [3:0] WR_PYS  = 4'd12;
  localparam logic [3:0] WR_PXS  = 4'd13;
  localparam logic [3:0] WR_PYC  = 4'd14;
  localparam logic [3:0] WR_SUM  = 4'd15;

  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [31:0] SIN_A   = 32'd1686629713;
  localparam logic [31:0] SIN_B   = 32'd693598668;
  localparam logic [31:0] SIN_C   = 32'd85569306;
  localparam logic [31:0] SIN_D   = 32'd5026995;
  localparam logic [31:0] COS_E   = 32'd1324675879;
  localparam logic [31:0] COS_F   = 32'd272375560;
  localparam logic [31:0] COS_G   = 32'd22401992;
  localparam logic [31:0] COS_H   = 32'd987048;

  localparam logic [13:0] HALF_QUAD   = 14'h2000;
  localparam logic [14:0] FULL_QUAD   = 15'h4000;
  localparam logic [31:0] WHITE       = 32'hFFFF_FFFF;
  localparam logic [15:0] TILE_ONE    = 16'h0100;
  localparam logic [14:0] LIMIT_RESET = 15'd16384;
  localparam logic [63:0] ROUND_HALF  = 64'h0000_0000_4000_0000;

  localparam logic [4:0] LAST_STEP = 5'd17;

endpackage

FILE: hdl/sprite_quad_vertex_expander_unit.sv
// Sequence: 18 sine/cosine and product steps on one shared multiplier, then a wait
//   for the texture slot scan (one table entry per cycle), then a corner state and an
//   emit state per corner; the emit state holds while the vertex output is stalled.
// A new quad is taken only in idle, after the last vertex of the previous one is emitted.
// Reset (rst, synchronous): batch count and slot count cleared, quad limit 16384,
//   no vertex pending. The slot table holds no reset value.
module sprite_quad_vertex_expander_unit #(
  parameter int MAX_QUADS = 16384,
  parameter int TEX_SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           quad_valid,
  output logic           quad_ready,
  input  svx_pkg::quad_t quad,
  output logic           vert_valid,
  input  logic           vert_ready,
  output svx_pkg::vert_t vert,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [14:0]    cfg_data
);
  import svx_pkg::*;

  cmd_t      cmd;
  sts_t      sts;
  slot_res_t slot_res;
  logic      slot_done;
  logic      out_busy;

  assign cfg_ready     = 1'b1;
  assign sts.slot_done = slot_done;
  assign sts.out_busy  = out_busy;

  svx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  svx_slots #(
    .MAX_QUADS (MAX_QUADS),
    .TEX_SLOTS (TEX_SLOTS)
  ) u_slots (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.load),
    .quad      (quad),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .res       (slot_res),
    .done      (slot_done)
  );

  svx_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .quad       (quad),
    .slot_res   (slot_res),
    .vert_ready (vert_ready),
    .vert_valid (vert_valid),
    .vert       (vert),
    .out_busy   (out_busy)
  );

endmodule

FILE: hdl/svx_slots.sv
module svx_slots #(
  parameter int MAX_QUADS = 16384,
  parameter int TEX_SLOTS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  svx_pkg::quad_t    quad,
  input  logic              cfg_write,
  input  logic [14:0]       cfg_value,
  output svx_pkg::slot_res_t res,
  output logic              done
);
  import svx_pkg::*;

  localparam int CW = $clog2(MAX_QUADS + 1);
  localparam int LW = (CW > 15) ? CW : 15;
  localparam int SW = $clog2(TEX_SLOTS);
  localparam int DEPTH = TEX_SLOTS - 1;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0]   slot_table [DEPTH];
  logic [CW-1:0] count;
  logic [SW-1:0] used;
  logic [14:0]   limit;
  logic          busy;
  logic [SW-1:0] i;
  logic          flush;
  logic [15:0]   tid;
  logic [SW-1:0] slot;
  logic [CW-1:0] index;

  logic [LW-1:0] lim_eff;
  logic [CW-1:0] count0;
  logic [SW-1:0] used0;
  logic          flush0;
  logic          full;
  logic          miss;
  logic [SW-1:0] wr_idx;
  logic [SW+4:0] slot_ext;
  logic [CW+13:0] index_ext;

  always_comb begin
    if (limit == 15'd0) begin
      lim_eff = LW'(1);
    end else if (LW'(limit) > LW'(MAX_QUADS)) begin
      lim_eff = LW'(MAX_QUADS);
    end else begin
      lim_eff = LW'(limit);
    end
    count0 = quad.scene_start ? '0 : count;
    used0  = quad.scene_start ? '0 : used;
    flush0 = 1'b0;
    if (LW'(count0) >= lim_eff) begin
      count0 = '0;
      used0  = '0;
      flush0 = 1'b1;
    end
    full   = (used == SW'(DEPTH));
    miss   = (i == used);
    wr_idx = full ? '0 : used;
  end

  always_ff @(posedge clk) begin
    if (busy && miss) begin
      slot_table[wr_idx[IW-1:0]] <= tid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      used  <= '0;
      limit <= LIMIT_RESET;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      if (cfg_write) begin
        limit <= cfg_value;
      end
      if (start) begin
        flush <= flush0;
        tid   <= quad.texture_id;
        i     <= '0;
        if (quad.texture_id == 16'd0) begin
          count <= CW'(count0 + 1'b1);
          used  <= used0;
          index <= count0;
          slot  <= '0;
          done  <= 1'b1;
        end else begin
          count <= count0;
          used  <= used0;
          busy  <= 1'b1;
          done  <= 1'b0;
        end
      end else if (busy) begin
        if (miss) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (full) begin
            flush <= 1'b1;
            count <= CW'(1);
            index <= '0;
            used  <= SW'(1);
            slot  <= SW'(1);
          end else begin
            used  <= SW'(used + 1'b1);
            slot  <= SW'(used + 1'b1);
            index <= count;
            count <= CW'(count + 1'b1);
          end
        end else if (slot_table[i[IW-1:0]] == tid) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          slot  <= SW'(i + 1'b1);
          index <= count;
          count <= CW'(count + 1'b1);
        end else begin
          i <= SW'(i + 1'b1);
        end
      end
    end
  end

  assign slot_ext  = (SW + 5)'(slot);
  assign index_ext = (CW + 14)'(index);
  assign res.slot  = slot_ext[4:0];
  assign res.index = index_ext[13:0];
  assign res.flush = flush;

endmodule

FILE: hdl/svx_dp.sv
module svx_dp (
  input  logic               clk,
  input  logic               rst,
  input  svx_pkg::cmd_t      cmd,
  input  svx_pkg::quad_t     quad,
  input  svx_pkg::slot_res_t slot_res,
  input  logic               vert_ready,
  output logic               vert_valid,
  output svx_pkg::vert_t     vert,
  output logic               out_busy
);
  import svx_pkg::*;

  quad_t              q;
  logic [29:0]        xr;
  logic               swap;
  logic [1:0]         quadrant;
  logic signed [65:0] prod;
  logic [29:0]        x2;
  logic [31:0]        ts;
  logic [31:0]        tc;
  logic [31:0]        sin0;
  logic [31:0]        cos0;
  logic signed [31:0] s;
  logic signed [31:0] c;
  logic signed [63:0] pxc, pys, pxs, pyc;
  logic signed [63:0] u, w, m, n;
  logic signed [32:0] ox, oy;

  logic [13:0]        r_eff;
  logic signed [32:0] ma, mb;
  logic [31:0]        hi;
  logic [31:0]        s0, c0;
  logic [63:0]        vx, vy, ax, ay, sx_sum, sy_sum;

  function automatic logic signed [31:0] sat(input logic signed [31:0] p,
                                             input logic signed [32:0] o);
    logic signed [33:0] t;
    t = {{2{p[31]}}, p} + {o[32], o};
    if (t > 34'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (t < -34'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = t[31:0];
    end
  endfunction

  assign r_eff = (quad.angle[13:0] <= HALF_QUAD) ? quad.angle[13:0]
               : 14'(FULL_QUAD - {1'b0, quad.angle[13:0]});
  assign hi    = prod[61:30];

  always_comb begin
    case (cmd.mul_sel)
      MUL_XX: begin
        ma = {3'b0, xr};
        mb = {3'b0, xr};
      end
      MUL_X2D: begin
        ma = {3'b0, x2};
        mb = {1'b0, SIN_D};
      end
      MUL_X2H: begin
        ma = {3'b0, x2};
        mb = {1'b0, COS_H};
      end
      MUL_X2TS: begin
        ma = {3'b0, x2};
        mb = {1'b0, ts};
      end
      MUL_X2TC: begin
        ma = {3'b0, x2};
        mb = {1'b0, tc};
      end
      MUL_XTS: begin
        ma = {3'b0, xr};
        mb = {1'b0, ts};
      end
      MUL_SXC: begin
        ma = {q.size_x[31], q.size_x};
        mb = {c[31], c};
      end
      MUL_SYS: begin
        ma = {q.size_y[31], q.size_y};
        mb = {s[31], s};
      end
      MUL_SXS: begin
        ma = {q.size_x[31], q.size_x};
        mb = {s[31], s};
      end
      MUL_SYC: begin
        ma = {q.size_y[31], q.size_y};
        mb = {c[31], c};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    s0 = swap ? cos0 : sin0;
    c0 = swap ? sin0 : cos0;
    case (cmd.k)
      2'd0: begin
        vx = ~u;
        ax = ROUND_HALF + 64'd1;
        vy = ~m;
        ay = ROUND_HALF + 64'd1;
      end
      2'd1: begin
        vx = w;
        ax = ROUND_HALF;
        vy = n;
        ay = ROUND_HALF;
      end
      2'd2: begin
        vx = u;
        ax = ROUND_HALF;
        vy = m;
        ay = ROUND_HALF;
      end
      default: begin
        vx = ~w;
        ax = ROUND_HALF + 64'd1;
        vy = ~n;
        ay = ROUND_HALF + 64'd1;
      end
    endcase
    sx_sum = vx + ax;
    sy_sum = vy + ay;
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (cmd.load) begin
      q        <= quad;
      xr       <= {r_eff, 16'b0};
      swap     <= (quad.angle[13:0] > HALF_QUAD);
      quadrant <= quad.angle[15:14];
    end
    case (cmd.wr_sel)
      WR_X2:   x2   <= prod[59:30];
      WR_TS_C: ts   <= SIN_C - hi;
      WR_TC_G: tc   <= COS_G - hi;
      WR_TS_B: ts   <= SIN_B - hi;
      WR_TC_F: tc   <= COS_F - hi;
      WR_TS_A: ts   <= SIN_A - hi;
      WR_TC_E: tc   <= COS_E - hi;
      WR_SIN:  sin0 <= hi;
      WR_COS:  cos0 <= ONE_Q30 - hi;
      WR_SC: begin
        case (quadrant)
          2'd0: begin
            c <= c0;
            s <= s0;
          end
          2'd1: begin
            c <= 32'(-s0);
            s <= c0;
          end
          2'd2: begin
            c <= 32'(-c0);
            s <= 32'(-s0);
          end
          default: begin
            c <= s0;
            s <= 32'(-c0);
          end
        endcase
      end
      WR_PXC:  pxc <= prod[63:0];
      WR_PYS:  pys <= prod[63:0];
      WR_PXS:  pxs <= prod[63:0];
      WR_PYC:  pyc <= prod[63:0];
      WR_SUM: begin
        u <= pxc - pys;
        w <= pxc + pys;
        m <= pxs + pyc;
        n <= pxs - pyc;
      end
      default: begin
      end
    endcase
    if (cmd.corner) begin
      ox <= sx_sum[63:31];
      oy <= sy_sum[63:31];
    end
    if (cmd.emit) begin
      vert.vert_x           <= sat(q.pos_x, ox);
      vert.vert_y           <= sat(q.pos_y, oy);
      vert.vert_z           <= q.pos_z;
      vert.vert_color       <= (q.texture_id != 16'd0) ? WHITE : q.color;
      vert.tex_u            <= (cmd.k == 2'd1) || (cmd.k == 2'd2);
      vert.tex_v            <= cmd.k[1];
      vert.tex_slot         <= slot_res.slot;
      vert.vert_tiling      <= (q.texture_id != 16'd0) ? q.tiling : TILE_ONE;
      vert.flush_before     <= (cmd.k == 2'd0) && slot_res.flush;
      vert.batch_quad_index <= slot_res.index;
      vert.last_vertex      <= (cmd.k == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_valid <= 1'b0;
    end else if (cmd.emit) begin
      vert_valid <= 1'b1;
    end else if (vert_ready) begin
      vert_valid <= 1'b0;
    end
  end

  assign out_busy = vert_valid && !vert_ready;

endmodule

FILE: hdl/svx_ctrl.sv
module svx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          quad_valid,
  output logic          quad_ready,
  input  svx_pkg::sts_t sts,
  output svx_pkg::cmd_t cmd
);
  import svx_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ARITH  = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_CORNER = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state, state_next;
  logic [4:0] step, step_next;
  logic [1:0] k, k_next;

  function automatic logic [7:0] step_ops(input logic [4:0] st);
    case (st)
      5'd0:    step_ops = {MUL_XX,   WR_NONE};
      5'd1:    step_ops = {MUL_NONE, WR_X2};
      5'd2:    step_ops = {MUL_X2D,  WR_NONE};
      5'd3:    step_ops = {MUL_X2H,  WR_TS_C};
      5'd4:    step_ops = {MUL_X2TS, WR_TC_G};
      5'd5:    step_ops = {MUL_X2TC, WR_TS_B};
      5'd6:    step_ops = {MUL_X2TS, WR_TC_F};
      5'd7:    step_ops = {MUL_X2TC, WR_TS_A};
      5'd8:    step_ops = {MUL_XTS,  WR_TC_E};
      5'd9:    step_ops = {MUL_X2TC, WR_SIN};
      5'd10:   step_ops = {MUL_NONE, WR_COS};
      5'd11:   step_ops = {MUL_NONE, WR_SC};
      5'd12:   step_ops = {MUL_SXC,  WR_NONE};
      5'd13:   step_ops = {MUL_SYS,  WR_PXC};
      5'd14:   step_ops = {MUL_SXS,  WR_PYS};
      5'd15:   step_ops = {MUL_SYC,  WR_PXS};
      5'd16:   step_ops = {MUL_NONE, WR_PYC};
      5'd17:   step_ops = {MUL_NONE, WR_SUM};
      default: step_ops = {MUL_NONE, WR_NONE};
    endcase
  endfunction

  always_comb begin
    state_next  = state;
    step_next   = step;
    k_next      = k;
    quad_ready  = 1'b0;
    cmd         = '0;
    cmd.mul_sel = MUL_NONE;
    cmd.wr_sel  = WR_NONE;
    cmd.k       = k;
    case (state)
      S_IDLE: begin
        quad_ready = 1'b1;
        if (quad_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = S_ARITH;
        end
      end
      S_ARITH: begin
        {cmd.mul_sel, cmd.wr_sel} = step_ops(step);
        if (step == LAST_STEP) begin
          state_next = S_WAIT;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_WAIT: begin
        if (sts.slot_done) begin
          k_next     = 2'd0;
          state_next = S_CORNER;
        end
      end
      S_CORNER: begin
        cmd.corner = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          if (k == 2'd3) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + 2'd1;
            state_next = S_CORNER;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      k     <= k_next;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import svx_pkg::*;

  localparam int QUAD_LIMIT_MAX = 16384;
  localparam int SLOT_COUNT = 31;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic quad_valid;
  logic quad_ready;
  quad_t quad;
  logic vert_valid;
  logic vert_ready;
  vert_t vert;
  logic cfg_valid;
  logic cfg_ready;
  logic [14:0] cfg_data;

  sprite_quad_vertex_expander_unit u_top (
    .clk(clk), .rst(rst),
    .quad_valid(quad_valid), .quad_ready(quad_ready), .quad(quad),
    .vert_valid(vert_valid), .vert_ready(vert_ready), .vert(vert),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  quad_t pending_quads[$];
  vert_t expected_verts[$];
  logic [15:0] tex_ids[SLOT_COUNT];
  int unsigned tex_count;
  int unsigned batch_count;
  int unsigned quad_limit;
  int errors;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int stall_phase;
  bit feeding_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned poly_sin(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = SIN_D;
    t = SIN_C - ((x2 * t) >> 30);
    t = SIN_B - ((x2 * t) >> 30);
    t = SIN_A - ((x2 * t) >> 30);
    return (x * t) >> 30;
  endfunction

  function automatic longint unsigned poly_cos(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = COS_H;
    t = COS_G - ((x2 * t) >> 30);
    t = COS_F - ((x2 * t) >> 30);
    t = COS_E - ((x2 * t) >> 30);
    return ONE_Q30 - ((x2 * t) >> 30);
  endfunction

  function automatic logic signed [31:0] sat_add(longint base, longint num);
    longint sum;
    sum = base + ((num + longint'(ONE_Q30)) >>> 31);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  task automatic expand_quad(input quad_t q);
    int unsigned lim, slot;
    bit flush;
    logic [31:0] col;
    logic [15:0] til;
    logic [13:0] idx;
    longint s0, c0, s, c, sx, sy, pxc, pys, pxs, pyc, nx, ny;
    logic [13:0] r;
    vert_t v;
    if (q.scene_start) begin
      batch_count = 0;
      tex_count = 0;
    end
    lim = quad_limit;
    if (lim < 1) lim = 1;
    if (lim > QUAD_LIMIT_MAX) lim = QUAD_LIMIT_MAX;
    flush = 0;
    if (batch_count >= lim) begin
      batch_count = 0;
      tex_count = 0;
      flush = 1;
    end
    slot = 0;
    col = q.color;
    til = q.tiling;
    if (q.texture_id != 0) begin
      for (int i = 0; i < tex_count; i++)
        if (slot == 0 && tex_ids[i] == q.texture_id) slot = i + 1;
      if (slot == 0) begin
        if (tex_count >= SLOT_COUNT) begin
          batch_count = 0;
          tex_count = 0;
          flush = 1;
        end
        tex_ids[tex_count] = q.texture_id;
        tex_count++;
        slot = tex_count;
      end
      col = WHITE;
    end else begin
      til = TILE_ONE;
    end
    idx = batch_count[13:0];
    batch_count++;
    r = q.angle[13:0];
    if (r <= HALF_QUAD) begin
      s0 = poly_sin(longint'(r) << 16);
      c0 = poly_cos(longint'(r) << 16);
    end else begin
      s0 = poly_cos(longint'(FULL_QUAD - r) << 16);
      c0 = poly_sin(longint'(FULL_QUAD - r) << 16);
    end
    case (q.angle[15:14])
      2'd0: begin c = c0; s = s0; end
      2'd1: begin c = -s0; s = c0; end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
    sx = q.size_x;
    sy = q.size_y;
    pxc = sx * c;
    pys = sy * s;
    pxs = sx * s;
    pyc = sy * c;
    for (int k = 0; k < 4; k++) begin
      v.tex_u = (k == 1 || k == 2);
      v.tex_v = (k >= 2);
      nx = (v.tex_u ? pxc : -pxc) - (v.tex_v ? pys : -pys);
      ny = (v.tex_u ? pxs : -pxs) + (v.tex_v ? pyc : -pyc);
      v.vert_x = sat_add(longint'(q.pos_x), nx);
      v.vert_y = sat_add(longint'(q.pos_y), ny);
      v.vert_z = q.pos_z;
      v.vert_color = col;
      v.tex_slot = slot[4:0];
      v.vert_tiling = til;
      v.flush_before = (k == 0) ? flush : 1'b0;
      v.batch_quad_index = idx;
      v.last_vertex = (k == 3);
      expected_verts.push_back(v);
    end
  endtask

  function automatic quad_t random_quad(int unsigned tex_span, bit wide);
    quad_t q;
    q.pos_x = wide ? $urandom : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    q.pos_y = wide ? $urandom : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    q.pos_z = $urandom;
    q.size_x = wide ? $urandom : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    q.size_y = wide ? $urandom : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    q.angle = 16'($urandom);
    q.color = $urandom;
    q.texture_id = ($urandom_range(0, 3) == 0) ? 16'd0 :
                   (wide ? 16'($urandom) : 16'($urandom_range(1, tex_span)));
    q.tiling = 16'($urandom);
    q.scene_start = ($urandom_range(0, 40) == 0);
    return q;
  endfunction

  task automatic run_phase(input int count, input int unsigned tex_span);
    for (int i = 0; i < count; i++)
      pending_quads.push_back(random_quad(tex_span, $urandom_range(0, 4) == 0));
    wait (pending_quads.size() == 0 && expected_verts.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(input logic [14:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    quad_limit = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (quad_valid && quad_ready) begin
        expand_quad(quad);
        void'(pending_quads.pop_front());
      end
      if (quad_valid && !quad_ready) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        quad_valid <= 1'b0;
      end else if (pending_quads.size() > 0) begin
        quad <= pending_quads[0];
        quad_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        quad_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      vert_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (vert_valid && vert_ready) begin
        if (expected_verts.size() == 0) begin
          $display("%0t: unexpected vertex %h", $time, vert);
          errors++;
        end else begin
          if (vert !== expected_verts[0]) begin
            $display("%0t: vertex mismatch expected %h actual %h", $time,
                     expected_verts[0], vert);
            errors++;
          end
          void'(expected_verts.pop_front());
        end
      end
      stall_phase <= stall_phase + 1;
      case (stall_phase[9:8])
        2'd0: vert_ready <= 1'b1;
        2'd1: vert_ready <= stall_phase[2] | stall_phase[4];
        2'd2: vert_ready <= ($urandom_range(0, 2) == 0);
        default: vert_ready <= (stall_phase[5:0] == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (quad_valid && quad_ready) || (vert_valid && vert_ready) ||
        feeding_done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    quad_t q;
    errors = 0;
    feeding_done = 0;
    tex_count = 0;
    batch_count = 0;
    quad_limit = LIMIT_RESET;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quad = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    q = '0;
    q.color = 32'h1234_5678;
    q.size_x = 32'sh0001_0000;
    q.size_y = 32'sh0002_0000;
    for (int b = 0; b < 16; b++) begin
      q.angle = 16'h0001 << b;
      pending_quads.push_back(q);
    end
    q.angle = 16'h2000;
    pending_quads.push_back(q);
    q.pos_x = 32'sh7FFF_FFFF;
    q.pos_y = 32'sh8000_0000;
    q.size_x = 32'sh7FFF_FFFF;
    q.size_y = 32'sh8000_0000;
    q.angle = 16'h0000;
    q.texture_id = 16'hFFFF;
    q.tiling = 16'hFFFF;
    pending_quads.push_back(q);
    q.size_x = 32'sh8000_0000;
    q.size_y = 32'sh7FFF_FFFF;
    q.angle = 16'hFFFF;
    q.pos_z = 32'hFFFF_FFFF;
    q.color = 32'hFFFF_FFFF;
    pending_quads.push_back(q);
    q.texture_id = 16'd0;
    q.scene_start = 1'b1;
    pending_quads.push_back(q);
    for (int i = 1; i <= 32; i++) begin
      q = random_quad(1, 0);
      q.texture_id = i;
      q.scene_start = 1'b0;
      if (i < 4 || i > 29) pending_quads.push_back(q);
      else pending_quads.push_back(q);
    end
    wait (pending_quads.size() == 0 && expected_verts.size() == 0);
    repeat (40) @(posedge clk);

    write_limit(15'd1);
    run_phase(40, 6);
    write_limit(15'd0);
    run_phase(30, 6);
    write_limit(15'd5);
    run_phase(120, 40);
    write_limit(15'h7FFF);
    run_phase(60, 8);
    write_limit(15'd16384);
    run_phase(120, 45);
    write_limit(15'd3);
    run_phase(40, 4);

    feeding_done = 1;
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
